// ===== design/sdtq_pkg.sv =====
`default_nettype none

package sdtq_pkg;

    localparam int SLOTS    = 16;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int TIME_W   = 48;
    localparam int DELAY_W  = 32;
    localparam int KIND_W   = 8;
    localparam int CTX_W    = 16;
    localparam int HANDLE_W = 4;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_CHECK = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        STATUS_DONE    = 2'd0,
        STATUS_NONE    = 2'd1,
        STATUS_FULL    = 2'd2,
        STATUS_UNARMED = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_WALK,
        ST_DEL_WALK,
        ST_CHK_ORD,
        ST_CHK_SLOT,
        ST_CHK_EVAL,
        ST_HEAD_ORD,
        ST_HEAD_SLOT,
        ST_HEAD_CAP,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0] deadline;
        logic [KIND_W-1:0] kind;
        logic [CTX_W-1:0]  context_tag;
    } slot_entry_t;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        slot_entry_t       wdata;
        logic [SLOT_W-1:0] raddr;
    } slot_cmd_t;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [SLOT_W-1:0] wdata;
        logic              re;
        logic [SLOT_W-1:0] raddr;
    } ord_cmd_t;

endpackage

`default_nettype wire

// ===== design/sdtq_slot_ram.sv =====
`default_nettype none

module sdtq_slot_ram (
    input  wire logic                aclk,
    input  wire sdtq_pkg::slot_cmd_t cmd,
    output sdtq_pkg::slot_entry_t    rdata
);
    import sdtq_pkg::*;

    slot_entry_t mem_reg [SLOTS];
    slot_entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (cmd.we) begin
            mem_reg[cmd.waddr] <= cmd.wdata;
        end
        rdata_reg <= mem_reg[cmd.raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/sdtq_order_ram.sv =====
`default_nettype none

module sdtq_order_ram (
    input  wire logic                        aclk,
    input  wire sdtq_pkg::ord_cmd_t          cmd,
    output logic [sdtq_pkg::SLOT_W-1:0]      rdata
);
    import sdtq_pkg::*;

    logic [SLOT_W-1:0] mem_reg [SLOTS];
    logic [SLOT_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (cmd.we) begin
            mem_reg[cmd.waddr] <= cmd.wdata;
        end
        if (cmd.re) begin
            rdata_reg <= mem_reg[cmd.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/sdtq_ctrl.sv =====
`default_nettype none

module sdtq_ctrl (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [1:0]                     s_opcode,
    input  wire logic [sdtq_pkg::TIME_W-1:0]    s_now,
    input  wire logic [sdtq_pkg::DELAY_W-1:0]   s_delay,
    input  wire logic [sdtq_pkg::KIND_W-1:0]    s_kind,
    input  wire logic [sdtq_pkg::CTX_W-1:0]     s_context_req,
    input  wire logic [sdtq_pkg::HANDLE_W-1:0]  s_handle,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [1:0]                          m_status,
    output logic [sdtq_pkg::HANDLE_W-1:0]       m_timer_handle,
    output logic [sdtq_pkg::KIND_W-1:0]         m_expired_kind,
    output logic [sdtq_pkg::CTX_W-1:0]          m_expired_context,
    output logic                                m_head_valid,
    output logic [sdtq_pkg::TIME_W-1:0]         m_head_deadline,
    output sdtq_pkg::slot_cmd_t                 slot_cmd,
    input  wire sdtq_pkg::slot_entry_t          slot_rdata,
    output sdtq_pkg::ord_cmd_t                  ord_cmd,
    input  wire logic [sdtq_pkg::SLOT_W-1:0]    ord_rdata
);
    import sdtq_pkg::*;

    // control state
    state_t            state_reg,    state_next;
    logic [SLOTS-1:0]  armed_reg,    armed_next;
    logic [CNT_W-1:0]  count_reg,    count_next;
    logic              issue_en_reg, issue_en_next;
    logic              p1_valid_reg, p1_valid_next;
    logic              p2_valid_reg, p2_valid_next;
    logic              found_reg,    found_next;
    logic              m_valid_reg,  m_valid_next;

    // datapath
    logic [CNT_W-1:0]  rd_idx_reg,   rd_idx_next;
    logic [CNT_W-1:0]  p1_idx_reg,   p1_idx_next;
    logic              p1_sent_reg,  p1_sent_next;
    logic [CNT_W-1:0]  p2_idx_reg,   p2_idx_next;
    logic [SLOT_W-1:0] p2_slot_reg,  p2_slot_next;
    logic              p2_sent_reg,  p2_sent_next;
    logic [SLOT_W-1:0] key_reg,      key_next;
    logic [SLOT_W-1:0] new_slot_reg, new_slot_next;
    logic [TIME_W-1:0] new_dl_reg,   new_dl_next;
    logic [TIME_W-1:0] now_reg,      now_next;
    logic [SLOT_W-1:0] chk_slot_reg, chk_slot_next;

    status_t           res_status_reg, res_status_next;
    logic [SLOT_W-1:0] res_handle_reg, res_handle_next;
    logic [KIND_W-1:0] res_kind_reg,   res_kind_next;
    logic [CTX_W-1:0]  res_ctx_reg,    res_ctx_next;
    logic              res_hvalid_reg, res_hvalid_next;
    logic [TIME_W-1:0] res_hdl_reg,    res_hdl_next;

    status_t           m_status_reg,   m_status_next;
    logic [SLOT_W-1:0] m_handle_reg,   m_handle_next;
    logic [KIND_W-1:0] m_kind_reg,     m_kind_next;
    logic [CTX_W-1:0]  m_ctx_reg,      m_ctx_next;
    logic              m_hvalid_reg,   m_hvalid_next;
    logic [TIME_W-1:0] m_hdl_reg,      m_hdl_next;

    logic              s_acc;
    logic              full;
    logic [SLOT_W-1:0] free_slot;
    logic [TIME_W:0]   dl_sum;
    logic [TIME_W-1:0] dl_sat;
    logic              stop_hit;
    logic              ins_stop;
    logic              del_last;
    logic              issue_last;
    logic [CNT_W-1:0]  del_wr_idx;
    logic [CNT_W-1:0]  ins_rd_idx;
    logic              chk_due;
    logic              out_free;

    assign s_acc     = s_valid && s_ready;
    assign full      = (count_reg == CNT_W'(SLOTS));
    assign dl_sum    = {1'b0, s_now} + (TIME_W + 1)'(s_delay);
    assign dl_sat    = dl_sum[TIME_W] ? {TIME_W{1'b1}} : dl_sum[TIME_W-1:0];
    assign stop_hit  = armed_reg[SLOT_W'(s_handle)];
    assign out_free  = !m_valid_reg || m_ready;

    // stop the insertion walk at the first entry (from the tail) not later than the new one
    assign ins_stop   = p2_valid_reg && (p2_sent_reg || (slot_rdata.deadline <= new_dl_reg));
    assign del_last   = p1_valid_reg && (p1_idx_reg == count_reg - CNT_W'(1));
    assign issue_last = (rd_idx_reg == count_reg - CNT_W'(1));
    assign del_wr_idx = p1_idx_reg - CNT_W'(1);
    assign ins_rd_idx = rd_idx_reg - CNT_W'(1);
    assign chk_due    = (slot_rdata.deadline <= now_reg);

    always_comb begin
        free_slot = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!armed_reg[i]) begin
                free_slot = SLOT_W'(i);
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    unique case (s_opcode)
                        OP_START: state_next = full ? ST_HEAD_ORD : ST_INS_WALK;
                        OP_STOP:  state_next = stop_hit ? ST_DEL_WALK : ST_HEAD_ORD;
                        OP_CHECK: state_next = (count_reg == '0) ? ST_HEAD_ORD : ST_CHK_ORD;
                        default:  state_next = ST_HEAD_ORD;
                    endcase
                end
            end
            ST_INS_WALK:  if (ins_stop) state_next = ST_HEAD_ORD;
            ST_DEL_WALK:  if (del_last) state_next = ST_HEAD_ORD;
            ST_CHK_ORD:   state_next = ST_CHK_SLOT;
            ST_CHK_SLOT:  state_next = ST_CHK_EVAL;
            ST_CHK_EVAL:  state_next = chk_due ? ST_DEL_WALK : ST_HEAD_ORD;
            ST_HEAD_ORD:  state_next = (count_reg == '0) ? ST_RESP : ST_HEAD_SLOT;
            ST_HEAD_SLOT: state_next = ST_HEAD_CAP;
            ST_HEAD_CAP:  state_next = ST_RESP;
            ST_RESP:      if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // memory commands and datapath
    always_comb begin
        slot_cmd        = '0;
        ord_cmd         = '0;
        armed_next      = armed_reg;
        count_next      = count_reg;
        issue_en_next   = issue_en_reg;
        p1_valid_next   = 1'b0;
        p2_valid_next   = 1'b0;
        found_next      = found_reg;
        rd_idx_next     = rd_idx_reg;
        p1_idx_next     = p1_idx_reg;
        p1_sent_next    = p1_sent_reg;
        p2_idx_next     = p2_idx_reg;
        p2_slot_next    = p2_slot_reg;
        p2_sent_next    = p2_sent_reg;
        key_next        = key_reg;
        new_slot_next   = new_slot_reg;
        new_dl_next     = new_dl_reg;
        now_next        = now_reg;
        chk_slot_next   = chk_slot_reg;
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        res_kind_next   = res_kind_reg;
        res_ctx_next    = res_ctx_reg;
        res_hvalid_next = res_hvalid_reg;
        res_hdl_next    = res_hdl_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_handle_next   = m_handle_reg;
        m_kind_next     = m_kind_reg;
        m_ctx_next      = m_ctx_reg;
        m_hvalid_next   = m_hvalid_reg;
        m_hdl_next      = m_hdl_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    res_status_next = STATUS_NONE;
                    res_handle_next = '0;
                    res_kind_next   = '0;
                    res_ctx_next    = '0;
                    now_next        = s_now;
                    issue_en_next   = 1'b0;
                    found_next      = 1'b0;
                    unique case (s_opcode)
                        OP_START: begin
                            if (full) begin
                                res_status_next = STATUS_FULL;
                            end else begin
                                // write the new timer now; the walk only reads listed slots
                                slot_cmd.we                = 1'b1;
                                slot_cmd.waddr             = free_slot;
                                slot_cmd.wdata.deadline    = dl_sat;
                                slot_cmd.wdata.kind        = s_kind;
                                slot_cmd.wdata.context_tag = s_context_req;
                                armed_next[free_slot]      = 1'b1;
                                new_slot_next              = free_slot;
                                new_dl_next                = dl_sat;
                                rd_idx_next                = count_reg;
                                issue_en_next              = 1'b1;
                                res_status_next            = STATUS_DONE;
                                res_handle_next            = free_slot;
                            end
                        end
                        OP_STOP: begin
                            if (stop_hit) begin
                                key_next        = SLOT_W'(s_handle);
                                rd_idx_next     = '0;
                                issue_en_next   = 1'b1;
                                res_status_next = STATUS_DONE;
                            end else begin
                                res_status_next = STATUS_UNARMED;
                            end
                        end
                        OP_CHECK: begin
                            res_status_next = STATUS_NONE;
                        end
                        default: begin
                            res_status_next = STATUS_NONE;
                        end
                    endcase
                end
            end

            ST_INS_WALK: begin
                // issue: walk the order list from the tail toward the head
                if (issue_en_reg) begin
                    p1_valid_next = 1'b1;
                    p1_idx_next   = rd_idx_reg;
                    p1_sent_next  = (rd_idx_reg == '0);
                    if (rd_idx_reg == '0) begin
                        issue_en_next = 1'b0;
                    end else begin
                        ord_cmd.re  = 1'b1;
                        ord_cmd.raddr = ins_rd_idx[SLOT_W-1:0];
                        rd_idx_next = ins_rd_idx;
                    end
                end
                // fetch the deadline of the listed slot
                if (p1_valid_reg) begin
                    slot_cmd.raddr = ord_rdata;
                    p2_valid_next  = 1'b1;
                    p2_idx_next    = p1_idx_reg;
                    p2_slot_next   = ord_rdata;
                    p2_sent_next   = p1_sent_reg;
                end
                // compare: shift one place down, or drop the new timer in
                if (p2_valid_reg) begin
                    ord_cmd.we    = 1'b1;
                    ord_cmd.waddr = p2_idx_reg[SLOT_W-1:0];
                    if (ins_stop) begin
                        ord_cmd.wdata = new_slot_reg;
                        count_next    = count_reg + CNT_W'(1);
                        issue_en_next = 1'b0;
                        p1_valid_next = 1'b0;
                        p2_valid_next = 1'b0;
                    end else begin
                        ord_cmd.wdata = p2_slot_reg;
                    end
                end
            end

            ST_DEL_WALK: begin
                if (issue_en_reg) begin
                    ord_cmd.re    = 1'b1;
                    ord_cmd.raddr = rd_idx_reg[SLOT_W-1:0];
                    p1_valid_next = 1'b1;
                    p1_idx_next   = rd_idx_reg;
                    rd_idx_next   = rd_idx_reg + CNT_W'(1);
                    if (issue_last) begin
                        issue_en_next = 1'b0;
                    end
                end
                // past the removed entry, pull each one up a place
                if (p1_valid_reg) begin
                    if (found_reg) begin
                        ord_cmd.we    = 1'b1;
                        ord_cmd.waddr = del_wr_idx[SLOT_W-1:0];
                        ord_cmd.wdata = ord_rdata;
                    end else if (ord_rdata == key_reg) begin
                        found_next = 1'b1;
                    end
                end
                if (del_last) begin
                    count_next          = count_reg - CNT_W'(1);
                    armed_next[key_reg] = 1'b0;
                    issue_en_next       = 1'b0;
                    p1_valid_next       = 1'b0;
                end
            end

            ST_CHK_ORD: begin
                ord_cmd.re    = 1'b1;
                ord_cmd.raddr = '0;
            end

            ST_CHK_SLOT: begin
                slot_cmd.raddr = ord_rdata;
                chk_slot_next  = ord_rdata;
            end

            ST_CHK_EVAL: begin
                if (chk_due) begin
                    res_status_next = STATUS_DONE;
                    res_handle_next = chk_slot_reg;
                    res_kind_next   = slot_rdata.kind;
                    res_ctx_next    = slot_rdata.context_tag;
                    key_next        = chk_slot_reg;
                    rd_idx_next     = '0;
                    issue_en_next   = 1'b1;
                    found_next      = 1'b0;
                end
            end

            ST_HEAD_ORD: begin
                if (count_reg == '0) begin
                    res_hvalid_next = 1'b0;
                    res_hdl_next    = '0;
                end else begin
                    ord_cmd.re    = 1'b1;
                    ord_cmd.raddr = '0;
                end
            end

            ST_HEAD_SLOT: begin
                slot_cmd.raddr = ord_rdata;
            end

            ST_HEAD_CAP: begin
                res_hvalid_next = 1'b1;
                res_hdl_next    = slot_rdata.deadline;
            end

            ST_RESP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_handle_next = res_handle_reg;
                    m_kind_next   = res_kind_reg;
                    m_ctx_next    = res_ctx_reg;
                    m_hvalid_next = res_hvalid_reg;
                    m_hdl_next    = res_hdl_reg;
                end
            end

            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            armed_reg    <= '0;
            count_reg    <= '0;
            issue_en_reg <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            armed_reg    <= armed_next;
            count_reg    <= count_next;
            issue_en_reg <= issue_en_next;
            p1_valid_reg <= p1_valid_next;
            p2_valid_reg <= p2_valid_next;
            found_reg    <= found_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg     <= rd_idx_next;
        p1_idx_reg     <= p1_idx_next;
        p1_sent_reg    <= p1_sent_next;
        p2_idx_reg     <= p2_idx_next;
        p2_slot_reg    <= p2_slot_next;
        p2_sent_reg    <= p2_sent_next;
        key_reg        <= key_next;
        new_slot_reg   <= new_slot_next;
        new_dl_reg     <= new_dl_next;
        now_reg        <= now_next;
        chk_slot_reg   <= chk_slot_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        res_kind_reg   <= res_kind_next;
        res_ctx_reg    <= res_ctx_next;
        res_hvalid_reg <= res_hvalid_next;
        res_hdl_reg    <= res_hdl_next;
        m_status_reg   <= m_status_next;
        m_handle_reg   <= m_handle_next;
        m_kind_reg     <= m_kind_next;
        m_ctx_reg      <= m_ctx_next;
        m_hvalid_reg   <= m_hvalid_next;
        m_hdl_reg      <= m_hdl_next;
    end

    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_timer_handle    = HANDLE_W'(m_handle_reg);
    assign m_expired_kind    = m_kind_reg;
    assign m_expired_context = m_ctx_reg;
    assign m_head_valid      = m_hvalid_reg;
    assign m_head_deadline   = m_hdl_reg;

endmodule

`default_nettype wire

// ===== design/sorted_deadline_timer_queue.sv =====
// Every transaction ends by reading the head deadline for its result unless no timer is
// armed. Before that, a start that finds a free slot walks the order list from the tail to
// the new timer's place, a stop of an armed timer walks the whole list, and a check reads
// the head, if any, and, when it is due, walks the whole list to remove it.
// Throughput: one transaction at a time, set by the walk over the order-list memory, one
// entry a cycle; the next transaction is taken while the result waits in its register.
// Reset (aresetn, synchronous, active low) clears the armed bits, the timer count and the
// control state at once; the slot and order memories are not cleared.
`default_nettype none

module sorted_deadline_timer_queue (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [1:0]                     s_opcode,
    input  wire logic [sdtq_pkg::TIME_W-1:0]    s_now,
    input  wire logic [sdtq_pkg::DELAY_W-1:0]   s_delay,
    input  wire logic [sdtq_pkg::KIND_W-1:0]    s_kind,
    input  wire logic [sdtq_pkg::CTX_W-1:0]     s_context_req,
    input  wire logic [sdtq_pkg::HANDLE_W-1:0]  s_handle,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [1:0]                          m_status,
    output logic [sdtq_pkg::HANDLE_W-1:0]       m_timer_handle,
    output logic [sdtq_pkg::KIND_W-1:0]         m_expired_kind,
    output logic [sdtq_pkg::CTX_W-1:0]          m_expired_context,
    output logic                                m_head_valid,
    output logic [sdtq_pkg::TIME_W-1:0]         m_head_deadline
);
    import sdtq_pkg::*;

    slot_cmd_t         slot_cmd;
    slot_entry_t       slot_rdata;
    ord_cmd_t          ord_cmd;
    logic [SLOT_W-1:0] ord_rdata;

    sdtq_slot_ram u_slot_ram (
        .aclk  (aclk),
        .cmd   (slot_cmd),
        .rdata (slot_rdata)
    );

    sdtq_order_ram u_order_ram (
        .aclk  (aclk),
        .cmd   (ord_cmd),
        .rdata (ord_rdata)
    );

    sdtq_ctrl u_ctrl (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_now             (s_now),
        .s_delay           (s_delay),
        .s_kind            (s_kind),
        .s_context_req     (s_context_req),
        .s_handle          (s_handle),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_timer_handle    (m_timer_handle),
        .m_expired_kind    (m_expired_kind),
        .m_expired_context (m_expired_context),
        .m_head_valid      (m_head_valid),
        .m_head_deadline   (m_head_deadline),
        .slot_cmd          (slot_cmd),
        .slot_rdata        (slot_rdata),
        .ord_cmd           (ord_cmd),
        .ord_rdata         (ord_rdata)
    );

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a transaction is in progress");

    a_fail_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != STATUS_DONE) |->
            (m_expired_kind == '0) && (m_expired_context == '0) && (m_timer_handle == '0))
        else $error("failed transaction carries timer fields");

    a_empty_head_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_head_valid |-> (m_head_deadline == '0))
        else $error("head deadline nonzero with empty queue");

    a_order_rw_apart: assert property (@(posedge aclk) disable iff (!aresetn)
        ord_cmd.we && ord_cmd.re |-> (ord_cmd.waddr != ord_cmd.raddr))
        else $error("order list read and written at one entry");
`endif

endmodule

`default_nettype wire
